@@ design/mmicc_pkg.sv @@
// Package with the shared types and constants of the MMI code classifier.
package mmicc_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [3:0] part_tag;
        logic       done_res;
        logic [1:0] verdict;
        logic       special_dial;
        logic       whole_is_full;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ACT1  = 3'd1,
        PH_CODE  = 3'd2,
        PH_INFO  = 3'd3,
        PH_DIAL  = 3'd4,
        PH_FAIL  = 3'd5
    } phase_t;

    // Part tags
    localparam logic [3:0] TAG_ACTION    = 4'd0;
    localparam logic [3:0] TAG_CODE      = 4'd1;
    localparam logic [3:0] TAG_SEP       = 4'd2;
    localparam logic [3:0] TAG_HASH      = 4'd7;
    localparam logic [3:0] TAG_DIAL      = 4'd8;
    localparam logic [3:0] TAG_UNMATCHED = 4'd9;

    // Verdict codes
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_SHORT  = 2'd1;
    localparam logic [1:0] VERDICT_MMI    = 2'd2;
    localparam logic [1:0] VERDICT_MARKED = 2'd3;

    // Characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    // Register map (byte address bit 2 selects the register index)
    localparam logic REG_CALL_ACTIVE = 1'b0;

endpackage

@@ design/mmi_code_classifier_top.sv @@
// Top level of the MMI code classifier: character parser, verdict logic and APB register.
// Pipeline: an accepted character waits in the input register; its result is registered
// into out_data and out_valid when the output advances. Throughput: one character per
// cycle unless out_stall is high; on a stalled output the input register takes one more
// character, then in_stall holds the input until the result transaction completes.
// Reset: rst_n clears both valid flags, call_active and the parse state at once.
module mmi_code_classifier_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mmicc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mmicc_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mmicc_pkg::*;

    logic      call_active_reg;

    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;

    phase_t    phase_reg, phase_next;
    logic [1:0] code_digits_reg, code_digits_next;
    logic [2:0] info_index_reg, info_index_next;
    logic      action_single_reg, action_single_next;
    logic      dial_seen_reg, dial_seen_next;
    logic      first_is_mark_reg, first_is_mark_next;
    logic      first_hash_reg, first_hash_next;
    logic      first_is_one_reg, first_is_one_next;
    logic      short_ok_reg, short_ok_next;
    logic [1:0] char_count_reg, char_count_next;

    logic      advance;
    logic      accept;
    logic      digit;
    logic      is_star;
    logic      is_hash;
    logic      is_short;
    logic [3:0] tag;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CALL_ACTIVE) ? {31'd0, call_active_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_active_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CALL_ACTIVE))
        begin
            call_active_reg <= pwdata[0];
        end
    end

    // Handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= in_data;
        if (advance && in_valid_reg)
            out_reg <= out_next;
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_START;
            code_digits_reg   <= 2'd0;
            info_index_reg    <= 3'd0;
            action_single_reg <= 1'b0;
            dial_seen_reg     <= 1'b0;
            first_is_mark_reg <= 1'b0;
            first_hash_reg    <= 1'b0;
            first_is_one_reg  <= 1'b0;
            short_ok_reg      <= 1'b1;
            char_count_reg    <= 2'd0;
        end
        else if (advance && in_valid_reg)
        begin
            if (in_reg.last)
            begin
                phase_reg         <= PH_START;
                code_digits_reg   <= 2'd0;
                info_index_reg    <= 3'd0;
                action_single_reg <= 1'b0;
                dial_seen_reg     <= 1'b0;
                first_is_mark_reg <= 1'b0;
                first_hash_reg    <= 1'b0;
                first_is_one_reg  <= 1'b0;
                short_ok_reg      <= 1'b1;
                char_count_reg    <= 2'd0;
            end
            else
            begin
                phase_reg         <= phase_next;
                code_digits_reg   <= code_digits_next;
                info_index_reg    <= info_index_next;
                action_single_reg <= action_single_next;
                dial_seen_reg     <= dial_seen_next;
                first_is_mark_reg <= first_is_mark_next;
                first_hash_reg    <= first_hash_next;
                first_is_one_reg  <= first_is_one_next;
                short_ok_reg      <= short_ok_next;
                char_count_reg    <= char_count_next;
            end
        end
    end

    assign digit   = (in_reg.ch >= CH_ZERO) && (in_reg.ch <= CH_NINE);
    assign is_star = (in_reg.ch == CH_STAR);
    assign is_hash = (in_reg.ch == CH_HASH);

    always_comb
    begin
        phase_next         = phase_reg;
        code_digits_next   = code_digits_reg;
        info_index_next    = info_index_reg;
        action_single_next = action_single_reg;
        dial_seen_next     = dial_seen_reg;
        first_is_mark_next = first_is_mark_reg;
        first_hash_next    = first_hash_reg;
        first_is_one_next  = first_is_one_reg;
        tag                = TAG_UNMATCHED;

        // The first character of a string records what it was.
        if (char_count_reg == 2'd0)
        begin
            first_is_mark_next = is_star || is_hash;
            first_hash_next    = is_hash;
            first_is_one_next  = (in_reg.ch == CH_ONE);
        end
        char_count_next = (char_count_reg == 2'd3) ? 2'd3 : char_count_reg + 2'd1;
        short_ok_next   = short_ok_reg && digit;

        unique case (phase_reg)
            PH_START:
            begin
                if (is_star || is_hash)
                begin
                    tag        = TAG_ACTION;
                    phase_next = PH_ACT1;
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_ACT1:
            begin
                // "#*" is not a valid two-character action.
                if (is_hash || (is_star && !first_hash_reg))
                begin
                    tag                = TAG_ACTION;
                    action_single_next = 1'b0;
                    code_digits_next   = 2'd0;
                    phase_next         = PH_CODE;
                end
                else if (digit)
                begin
                    tag                = TAG_CODE;
                    action_single_next = 1'b1;
                    code_digits_next   = 2'd1;
                    phase_next         = PH_CODE;
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_CODE:
            begin
                if (digit && (code_digits_reg != 2'd3))
                begin
                    tag              = TAG_CODE;
                    code_digits_next = code_digits_reg + 2'd1;
                end
                else if (is_star && code_digits_reg[1])
                begin
                    tag             = TAG_SEP;
                    info_index_next = 3'd1;
                    phase_next      = PH_INFO;
                end
                else if (is_hash && code_digits_reg[1])
                begin
                    tag        = TAG_HASH;
                    phase_next = PH_DIAL;
                end
                else
                    phase_next = PH_FAIL;
            end
            PH_INFO:
            begin
                if (is_star)
                begin
                    if (!info_index_reg[2])
                    begin
                        tag             = TAG_SEP;
                        info_index_next = info_index_reg + 3'd1;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                else if (is_hash)
                begin
                    tag        = TAG_HASH;
                    phase_next = PH_DIAL;
                end
                else
                    tag = TAG_SEP + {1'b0, info_index_reg};
            end
            PH_DIAL:
            begin
                if ((in_reg.ch == CH_CR) || (in_reg.ch == CH_LF))
                    phase_next = PH_FAIL;
                else
                begin
                    tag            = TAG_DIAL;
                    dial_seen_next = 1'b1;
                end
            end
            default:
                phase_next = PH_FAIL;
        endcase

        if (call_active_reg)
            is_short = short_ok_next && (char_count_next != 2'd3);
        else
            is_short = short_ok_next && (char_count_next == 2'd2) && !first_is_one_next;

        out_next.part_tag      = tag;
        out_next.done_res      = in_reg.last;
        out_next.verdict       = VERDICT_NONE;
        out_next.special_dial  = 1'b0;
        out_next.whole_is_full = 1'b0;
        if (in_reg.last)
        begin
            if (is_short)
                out_next.verdict = VERDICT_SHORT;
            else if (phase_next == PH_DIAL)
            begin
                out_next.verdict       = VERDICT_MMI;
                out_next.special_dial  = action_single_next && dial_seen_next;
                out_next.whole_is_full = dial_seen_next && is_hash;
            end
            else if (first_is_mark_next && is_hash)
                out_next.verdict = VERDICT_MARKED;
        end
    end

    // A finished string leaves the parser at its start.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && in_reg.last) |=>
            (phase_reg == PH_START && char_count_reg == 2'd0 && short_ok_reg))
        else $error("parse state not cleared after last character");

    // Verdict fields stay zero on results that do not close a string.
    a_no_verdict_midstring: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.done_res) |->
            (out_data.verdict == VERDICT_NONE && !out_data.special_dial
             && !out_data.whole_is_full))
        else $error("verdict given before last character");

    // The dial flags only accompany a structured verdict.
    a_flags_need_mmi: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.special_dial || out_data.whole_is_full)) |->
            (out_data.verdict == VERDICT_MMI))
        else $error("dial flag without structured verdict");

    // Once the structure fails, every later character is unmatched.
    a_fail_tags_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && phase_reg == PH_FAIL) |-> (out_next.part_tag == TAG_UNMATCHED))
        else $error("tag given after structure failed");

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the MMI code classifier: directed table, random dialed strings, scoreboard.
`timescale 1ns / 1ps

module tb;
    import mmicc_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int CHARS_PER_PHASE = 135;
    localparam logic [2:0] ADDR_CALL_ACTIVE = {REG_CALL_ACTIVE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    always #4 clk = ~clk;

    mmi_code_classifier_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Directed stimulus row; want is used only where typed is set.
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       ca;
        logic       typed;
        out_item_t  want;
    } dir_row_t;

    dir_row_t   dir_rows[$];
    out_item_t  pending_results[$];
    logic [7:0] str_buf[$];
    int         err_count = 0;
    int         send_gap_pct = 0;
    int         recv_gap_pct = 0;
    bit         hold_armed = 1'b0;
    int         hold_left = 0;

    // Shadow copy of the classifier state.
    logic       cfg_call_active;
    phase_t     parse_ph;
    logic [1:0] code_n;
    logic [2:0] info_n;
    logic       act_single;
    logic       dial_seen;
    logic       first_mark;
    logic       first_one;
    logic       first_hash;
    logic       all_digits;
    logic [1:0] n_chars;

    task automatic report_err(input string msg);
        err_count++;
        if (err_count <= 30)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void clear_parse();
        parse_ph   = PH_START;
        code_n     = 2'd0;
        info_n     = 3'd0;
        act_single = 1'b0;
        dial_seen  = 1'b0;
        first_mark = 1'b0;
        first_one  = 1'b0;
        first_hash = 1'b0;
        all_digits = 1'b1;
        n_chars    = 2'd0;
    endfunction

    function automatic out_item_t classify_char(input in_item_t it);
        out_item_t  r;
        logic       is_digit;
        logic       is_star;
        logic       is_hash;
        logic       is_short;
        logic [3:0] tag;
        is_digit = (it.ch >= CH_ZERO) && (it.ch <= CH_NINE);
        is_star  = (it.ch == CH_STAR);
        is_hash  = (it.ch == CH_HASH);
        if (n_chars == 2'd0)
        begin
            first_mark = is_star || is_hash;
            first_hash = is_hash;
            first_one  = (it.ch == CH_ONE);
        end
        if (n_chars != 2'd3)
            n_chars = n_chars + 2'd1;
        if (!is_digit)
            all_digits = 1'b0;

        tag = TAG_UNMATCHED;
        case (parse_ph)
            PH_START:
                if (is_star || is_hash)
                begin
                    tag      = TAG_ACTION;
                    parse_ph = PH_ACT1;
                end
                else
                    parse_ph = PH_FAIL;
            PH_ACT1:
                if (is_hash || (is_star && !first_hash))
                begin
                    tag        = TAG_ACTION;
                    act_single = 1'b0;
                    code_n     = 2'd0;
                    parse_ph   = PH_CODE;
                end
                else if (is_digit)
                begin
                    tag        = TAG_CODE;
                    act_single = 1'b1;
                    code_n     = 2'd1;
                    parse_ph   = PH_CODE;
                end
                else
                    parse_ph = PH_FAIL;
            PH_CODE:
                if (is_digit && code_n < 2'd3)
                begin
                    tag    = TAG_CODE;
                    code_n = code_n + 2'd1;
                end
                else if (is_star && code_n >= 2'd2)
                begin
                    tag      = TAG_SEP;
                    info_n   = 3'd1;
                    parse_ph = PH_INFO;
                end
                else if (is_hash && code_n >= 2'd2)
                begin
                    tag      = TAG_HASH;
                    parse_ph = PH_DIAL;
                end
                else
                    parse_ph = PH_FAIL;
            PH_INFO:
                if (is_star)
                begin
                    if (info_n < 3'd4)
                    begin
                        tag    = TAG_SEP;
                        info_n = info_n + 3'd1;
                    end
                    else
                        parse_ph = PH_FAIL;
                end
                else if (is_hash)
                begin
                    tag      = TAG_HASH;
                    parse_ph = PH_DIAL;
                end
                else
                    tag = TAG_SEP + {1'b0, info_n};
            PH_DIAL:
                if (it.ch == CH_CR || it.ch == CH_LF)
                    parse_ph = PH_FAIL;
                else
                begin
                    tag       = TAG_DIAL;
                    dial_seen = 1'b1;
                end
            default:
                parse_ph = PH_FAIL;
        endcase

        r.part_tag      = tag;
        r.done_res      = it.last;
        r.verdict       = VERDICT_NONE;
        r.special_dial  = 1'b0;
        r.whole_is_full = 1'b0;
        if (it.last)
        begin
            if (cfg_call_active)
                is_short = all_digits && (n_chars <= 2'd2);
            else
                is_short = all_digits && (n_chars == 2'd2) && !first_one;
            if (is_short)
                r.verdict = VERDICT_SHORT;
            else if (parse_ph == PH_DIAL)
            begin
                r.verdict       = VERDICT_MMI;
                r.special_dial  = act_single && dial_seen;
                r.whole_is_full = dial_seen && is_hash;
            end
            else if (first_mark && is_hash)
                r.verdict = VERDICT_MARKED;
            clear_parse();
        end
        return r;
    endfunction

    task automatic add_row(input logic [7:0] c, input logic lst, input logic ca,
                           input logic typed, input logic [3:0] tag, input logic [1:0] vd,
                           input logic sp, input logic wh);
        dir_row_t r;
        r.ch                 = c;
        r.lst                = lst;
        r.ca                 = ca;
        r.typed              = typed;
        r.want.part_tag      = tag;
        r.want.done_res      = lst;
        r.want.verdict       = vd;
        r.want.special_dial  = sp;
        r.want.whole_is_full = wh;
        dir_rows.push_back(r);
    endtask

    // Offers one character and records its expected result once it is taken.
    task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
                             input out_item_t want);
        in_item_t  it;
        out_item_t pred;
        it.ch   = c;
        it.last = lst;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = classify_char(it);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_call_active(input logic v);
        logic [31:0] word;
        word    = $urandom();
        word[0] = v;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CALL_ACTIVE;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg_call_active = v;
        // Read the register back right after the write.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'd0, v})
            report_err($sformatf("call_active readback %h, want %0d", prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Builds one dialed string: mostly structured codes, then short codes, marked strings
    // and noise, with an occasional corrupted character.
    task automatic make_string();
        int kind;
        int n;
        int k;
        int r;
        str_buf.delete();
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            case ($urandom_range(5))
                0: str_buf.push_back(CH_STAR);
                1: str_buf.push_back(CH_HASH);
                2: begin str_buf.push_back(CH_STAR); str_buf.push_back(CH_STAR); end
                3: begin str_buf.push_back(CH_HASH); str_buf.push_back(CH_HASH); end
                4: begin str_buf.push_back(CH_STAR); str_buf.push_back(CH_HASH); end
                default: begin str_buf.push_back(CH_HASH); str_buf.push_back(CH_STAR); end
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(2, 3);
            repeat (n) str_buf.push_back(rand_digit());
            n = ($urandom_range(9) == 0) ? 5 : $urandom_range(0, 4);
            repeat (n)
            begin
                str_buf.push_back(CH_STAR);
                k = $urandom_range(0, 3);
                repeat (k)
                    str_buf.push_back(($urandom_range(7) == 0) ?
                                      8'($urandom_range(32, 126)) : rand_digit());
            end
            if ($urandom_range(99) < 85)
                str_buf.push_back(CH_HASH);
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                r = $urandom_range(19);
                if (r == 0)
                    str_buf.push_back(CH_CR);
                else if (r == 1)
                    str_buf.push_back(CH_LF);
                else
                    str_buf.push_back(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(3) == 0)
                str_buf.push_back(CH_HASH);
        end
        else if (kind < 75)
        begin
            n = $urandom_range(1, 3);
            repeat (n) str_buf.push_back(rand_digit());
        end
        else if (kind < 87)
        begin
            str_buf.push_back($urandom_range(1) ? CH_STAR : CH_HASH);
            n = $urandom_range(0, 3);
            repeat (n) str_buf.push_back(8'($urandom_range(255)));
            str_buf.push_back(CH_HASH);
        end
        else
        begin
            n = $urandom_range(1, 5);
            repeat (n) str_buf.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0)
            str_buf[$urandom_range(str_buf.size() - 1)] = 8'($urandom_range(255));
    endtask

    // Receiver: random stall, plus one long hold-off when armed.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_err($sformatf("unexpected result %h", out_data));
            else
            begin
                want = pending_results.pop_front();
                if (out_data.part_tag !== want.part_tag)
                    report_err($sformatf("part_tag %0d, want %0d",
                                         out_data.part_tag, want.part_tag));
                if (out_data.done_res !== want.done_res)
                    report_err($sformatf("done_res %0d, want %0d",
                                         out_data.done_res, want.done_res));
                if (out_data.verdict !== want.verdict)
                    report_err($sformatf("verdict %0d, want %0d",
                                         out_data.verdict, want.verdict));
                if (out_data.special_dial !== want.special_dial)
                    report_err($sformatf("special_dial %0d, want %0d",
                                         out_data.special_dial, want.special_dial));
                if (out_data.whole_is_full !== want.whole_is_full)
                    report_err($sformatf("whole_is_full %0d, want %0d",
                                         out_data.whole_is_full, want.whole_is_full));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int sent;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_call_active = 1'b0;
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_call_active(1'b0);

        // An extreme character as a one-character string.
        add_row(8'h00, 1, 0, 1, TAG_UNMATCHED, VERDICT_NONE, 0, 0);
        // Two-digit short code.
        add_row("2",   0, 0, 1, TAG_UNMATCHED, VERDICT_NONE, 0, 0);
        add_row("2",   1, 0, 1, TAG_UNMATCHED, VERDICT_SHORT, 0, 0);
        // Hash then star is not an action.
        add_row(CH_HASH, 0, 0, 1, TAG_ACTION, VERDICT_NONE, 0, 0);
        add_row(CH_STAR, 1, 0, 1, TAG_UNMATCHED, VERDICT_NONE, 0, 0);
        // Line feed in the dial remainder breaks the structure.
        add_row(CH_STAR, 0, 0, 1, TAG_ACTION, VERDICT_NONE, 0, 0);
        add_row("2",     0, 0, 1, TAG_CODE, VERDICT_NONE, 0, 0);
        add_row("1",     0, 0, 1, TAG_CODE, VERDICT_NONE, 0, 0);
        add_row(CH_HASH, 0, 0, 1, TAG_HASH, VERDICT_NONE, 0, 0);
        add_row(CH_LF,   1, 0, 1, TAG_UNMATCHED, VERDICT_NONE, 0, 0);
        // Fourth service code digit.
        add_row(CH_STAR, 0, 0, 1, TAG_ACTION, VERDICT_NONE, 0, 0);
        add_row("1",     0, 0, 1, TAG_CODE, VERDICT_NONE, 0, 0);
        add_row("2",     0, 0, 1, TAG_CODE, VERDICT_NONE, 0, 0);
        add_row("3",     0, 0, 1, TAG_CODE, VERDICT_NONE, 0, 0);
        add_row("4",     1, 0, 1, TAG_UNMATCHED, VERDICT_NONE, 0, 0);
        // Fifth info field.
        add_row(CH_STAR, 0, 0, 0, '0, '0, 0, 0);
        add_row("2",     0, 0, 0, '0, '0, 0, 0);
        add_row("1",     0, 0, 0, '0, '0, 0, 0);
        repeat (4) add_row(CH_STAR, 0, 0, 0, '0, '0, 0, 0);
        add_row(CH_STAR, 1, 0, 0, '0, '0, 0, 0);
        // Full structured string with a one-character action and a dial remainder.
        add_row(CH_STAR, 0, 0, 0, '0, '0, 0, 0);
        add_row("2",     0, 0, 0, '0, '0, 0, 0);
        add_row("1",     0, 0, 0, '0, '0, 0, 0);
        add_row(CH_HASH, 0, 0, 0, '0, '0, 0, 0);
        add_row(8'hFF,   0, 0, 0, '0, '0, 0, 0);
        add_row(CH_HASH, 1, 0, 1, TAG_DIAL, VERDICT_MMI, 1, 1);
        // One digit is a short code while a call is active.
        add_row("5",     1, 1, 1, TAG_UNMATCHED, VERDICT_SHORT, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].ca != cfg_call_active)
            begin
                settle();
                write_call_active(dir_rows[i].ca);
            end
            send_char(dir_rows[i].ch, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < 3; p++)
        begin
            settle();
            case (p)
                0: begin send_gap_pct = 29; recv_gap_pct = 61; write_call_active(1'b1); end
                1: begin send_gap_pct = 61; recv_gap_pct = 29; write_call_active(1'b0); end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                    write_call_active(1'($urandom_range(1)));
                    hold_armed = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < CHARS_PER_PHASE)
            begin
                make_string();
                foreach (str_buf[j])
                begin
                    send_char(str_buf[j], (j == str_buf.size() - 1), 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mmicc_pkg.sv
design/mmi_code_classifier_top.sv
tb/sv/tb.sv
